FILE: hw/rtl/rct_pkg.sv
// ----------------------------------------------------------------------------
// Reference count tracker package
// Shared sizes, opcodes, status codes and the lookup result type.
// ----------------------------------------------------------------------------
package rct_pkg;

    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LIVE_BITS  = $clog2(ENTRIES + 1);

    localparam int ADDR_W     = 64;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int REFCNT_W   = 16;
    localparam int LIVEOUT_W  = 7;

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [LIVE_BITS-1:0]  live_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [OP_W-1:0]       op_t;
    typedef logic [STATUS_W-1:0]   status_t;

    localparam op_t OP_ALLOC   = 2'd0;
    localparam op_t OP_ADDREF  = 2'd1;
    localparam op_t OP_RELEASE = 2'd2;
    localparam op_t OP_LEAK    = 2'd3;

    localparam status_t ST_OK            = 3'd0;
    localparam status_t ST_ALLOC_LIVE    = 3'd1;
    localparam status_t ST_ADD_UNTRACKED = 3'd2;
    localparam status_t ST_ADD_RELEASED  = 3'd3;
    localparam status_t ST_REL_UNTRACKED = 3'd4;
    localparam status_t ST_REL_RELEASED  = 3'd5;
    localparam status_t ST_LEAK          = 3'd6;
    localparam status_t ST_FULL_SAT      = 3'd7;

    localparam count_t COUNT_MAX = '1;

    // Outcome of the parallel tag search for one address.
    typedef struct packed {
        logic hit;
        idx_t hit_idx;
        logic free_ok;
        idx_t free_idx;
    } lookup_t;

endpackage

FILE: hw/rtl/rct_tag_cam.sv
// ----------------------------------------------------------------------------
// Tag table
// Address tags and valid bits in flops, searched in parallel for a match
// and for the lowest free slot.
// ----------------------------------------------------------------------------
module rct_tag_cam (
    input  logic            clk,
    input  logic            rst_n,
    input  rct_pkg::addr_t  lookup_addr,
    input  logic            wr_en,
    input  rct_pkg::idx_t   wr_idx,
    input  rct_pkg::addr_t  wr_tag,
    output rct_pkg::lookup_t lookup
);

    rct_pkg::addr_t              tag_reg [rct_pkg::ENTRIES];
    logic [rct_pkg::ENTRIES-1:0] valid_reg;
    logic [rct_pkg::ENTRIES-1:0] match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_reg[wr_idx] <= wr_tag;
        end
    end

    always_comb
    begin
        for (int i = 0; i < rct_pkg::ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == lookup_addr);
        end
    end

    // Priority encoders: scanning downward leaves the lowest index selected.
    always_comb
    begin
        lookup = '0;
        for (int i = rct_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                lookup.hit     = 1'b1;
                lookup.hit_idx = rct_pkg::IDX_BITS'(i);
            end
            if (!valid_reg[i])
            begin
                lookup.free_ok  = 1'b1;
                lookup.free_idx = rct_pkg::IDX_BITS'(i);
            end
        end
    end

endmodule

FILE: hw/rtl/rct_count_ram.sv
// ----------------------------------------------------------------------------
// Count memory
// One-port-write, one-port-read synchronous memory holding the reference
// counts, with registered read data.
// ----------------------------------------------------------------------------
module rct_count_ram (
    input  logic            clk,
    input  logic            rd_en,
    input  rct_pkg::idx_t   rd_addr,
    output rct_pkg::count_t rd_data,
    input  logic            wr_en,
    input  rct_pkg::idx_t   wr_addr,
    input  rct_pkg::count_t wr_data
);

    rct_pkg::count_t mem [rct_pkg::ENTRIES];
    rct_pkg::count_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/reference_count_tracker.sv
// ----------------------------------------------------------------------------
// Reference count tracker
// Tracks object addresses with reference counts and flags misuse.
// ----------------------------------------------------------------------------
// Usage: a command word (opcode, object_address) is taken at a rising edge
// where start is high and busy is low. In that same cycle the address is
// compared against all tags in parallel and the count memory is read at the
// matching slot. The next cycle (busy high) updates the count, the tag table
// and the live counter, and registers the result, which shows on status,
// ref_count and live_objects for exactly one cycle with done high and
// cannot be held off. A new command cannot be taken while busy is high, as
// the count memory is read and then written back; a new command may be
// issued in the cycle where done is high. Busy interlocks the memory so a
// read never overlaps a pending write to the same entry.
// Reset clears all valid bits, the live counter and the control state at
// once; tags and counts need no clearing pass since they are only read for
// valid entries.
// ----------------------------------------------------------------------------
module reference_count_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rct_pkg::OP_W-1:0]        opcode,
    input  logic [rct_pkg::ADDR_W-1:0]      object_address,
    output logic                            done,
    output logic [rct_pkg::STATUS_W-1:0]    status,
    output logic [rct_pkg::REFCNT_W-1:0]    ref_count,
    output logic [rct_pkg::LIVEOUT_W-1:0]   live_objects
);

    logic              accept;
    rct_pkg::lookup_t  lookup;
    rct_pkg::lookup_t  lookup_reg;
    rct_pkg::op_t      op_reg;
    rct_pkg::addr_t    addr_reg;
    logic              busy_reg;
    logic              done_reg;
    rct_pkg::live_t    live_reg;
    rct_pkg::live_t    live_next;
    rct_pkg::status_t  status_reg;
    rct_pkg::status_t  status_next;
    rct_pkg::count_t   count_reg;
    rct_pkg::count_t   count_next;
    rct_pkg::count_t   cur_count;
    rct_pkg::idx_t     rd_idx;
    logic              tag_wr;
    logic              cnt_wr;
    rct_pkg::idx_t     cnt_wr_idx;
    rct_pkg::count_t   cnt_wr_data;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign rd_idx = lookup.hit ? lookup.hit_idx : lookup.free_idx;

    rct_tag_cam u_tags (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_addr (object_address),
        .wr_en       (tag_wr),
        .wr_idx      (lookup_reg.free_idx),
        .wr_tag      (addr_reg),
        .lookup      (lookup)
    );

    rct_count_ram u_counts (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_idx),
        .rd_data (cur_count),
        .wr_en   (cnt_wr),
        .wr_addr (cnt_wr_idx),
        .wr_data (cnt_wr_data)
    );

    always_comb
    begin
        status_next = rct_pkg::ST_OK;
        count_next  = '0;
        live_next   = live_reg;
        tag_wr      = 1'b0;
        cnt_wr      = 1'b0;
        cnt_wr_idx  = lookup_reg.hit_idx;
        cnt_wr_data = '0;
        case (op_reg)
            rct_pkg::OP_ALLOC:
            begin
                if (lookup_reg.hit)
                begin
                    if (cur_count != '0)
                    begin
                        status_next = rct_pkg::ST_ALLOC_LIVE;
                        count_next  = cur_count;
                    end
                    else
                    begin
                        // Revive a released entry.
                        cnt_wr      = 1'b1;
                        cnt_wr_data = rct_pkg::COUNT_BITS'(1);
                        count_next  = rct_pkg::COUNT_BITS'(1);
                        live_next   = live_reg + 1'b1;
                    end
                end
                else if (!lookup_reg.free_ok)
                begin
                    status_next = rct_pkg::ST_FULL_SAT;
                end
                else
                begin
                    tag_wr      = 1'b1;
                    cnt_wr      = 1'b1;
                    cnt_wr_idx  = lookup_reg.free_idx;
                    cnt_wr_data = rct_pkg::COUNT_BITS'(1);
                    count_next  = rct_pkg::COUNT_BITS'(1);
                    live_next   = live_reg + 1'b1;
                end
            end
            rct_pkg::OP_ADDREF:
            begin
                if (!lookup_reg.hit)
                begin
                    status_next = rct_pkg::ST_ADD_UNTRACKED;
                end
                else if (cur_count == '0)
                begin
                    status_next = rct_pkg::ST_ADD_RELEASED;
                end
                else if (cur_count == rct_pkg::COUNT_MAX)
                begin
                    status_next = rct_pkg::ST_FULL_SAT;
                    count_next  = cur_count;
                end
                else
                begin
                    cnt_wr      = 1'b1;
                    cnt_wr_data = cur_count + 1'b1;
                    count_next  = cur_count + 1'b1;
                end
            end
            rct_pkg::OP_RELEASE:
            begin
                if (!lookup_reg.hit)
                begin
                    status_next = rct_pkg::ST_REL_UNTRACKED;
                end
                else if (cur_count == '0)
                begin
                    status_next = rct_pkg::ST_REL_RELEASED;
                end
                else
                begin
                    cnt_wr      = 1'b1;
                    cnt_wr_data = cur_count - 1'b1;
                    count_next  = cur_count - 1'b1;
                    if ((cur_count == rct_pkg::COUNT_BITS'(1)) && (live_reg != '0))
                    begin
                        live_next = live_reg - 1'b1;
                    end
                end
            end
            rct_pkg::OP_LEAK:
            begin
                status_next = (live_reg != '0) ? rct_pkg::ST_LEAK : rct_pkg::ST_OK;
            end
            default:
            begin
                status_next = rct_pkg::ST_OK;
            end
        endcase
        // Updates happen only in the execute cycle.
        if (!busy_reg)
        begin
            tag_wr    = 1'b0;
            cnt_wr    = 1'b0;
            live_next = live_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            live_reg <= '0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= opcode;
            addr_reg   <= object_address;
            lookup_reg <= lookup;
        end
        if (busy_reg)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign ref_count    = rct_pkg::REFCNT_W'(count_reg);
    assign live_objects = rct_pkg::LIVEOUT_W'(live_reg);

endmodule
